FILE: rtl/core/ndf_pkg.sv
`default_nettype none

package ndf_pkg;

  localparam int unsigned TableDepthDefault = 65536;
  localparam int unsigned MaxNgramDefault   = 16;

  localparam int unsigned TokenW  = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned FpW     = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned NgramW  = 5;

  localparam logic [CfgIdxW-1:0] REG_GRAM_LEN = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_DEDUP_EN = 1'b1;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [NgramW-1:0] GRAM_LEN_RST = 5'd3;
  localparam logic              DEDUP_EN_RST = 1'b1;

  localparam logic [FpW-1:0] HASH_SEED = 64'd1315423911;
  localparam logic [FpW-1:0] HASH_MULT = 64'd2654435761;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CMP,
    ST_FLUSH,
    ST_FIN
  } ndf_state_e;

  // Weight of window position idx: seed times multiplier to the power idx, mod 2^64.
  function automatic logic [FpW-1:0] b_coef(input int unsigned idx);
    logic [FpW-1:0] b;
    int unsigned    k;
    b = HASH_SEED;
    for (k = 0; k < idx; k++) begin
      b = b * HASH_MULT;
    end
    return b;
  endfunction

  // Residue of v times 16 to the power pos, modulo depth.
  function automatic int unsigned nib_weight(input int unsigned pos, input int unsigned v,
                                             input int unsigned depth);
    logic [63:0] r;
    int unsigned k;
    r = 64'(v) % 64'(depth);
    for (k = 0; k < pos; k++) begin
      r = (r * 64'd16) % 64'(depth);
    end
    return 32'(r);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ngram_dedup_token_filter_core.sv
// N-gram duplicate filter for a token stream. Tokens are held in a row of window cells; once
// the configured n-gram size of tokens is held, their 64-bit fingerprint is computed one token
// per cycle and looked up in a direct-mapped fingerprint table at index fingerprint mod
// TABLE_DEPTH. A hit drops the oldest token, a miss stores the fingerprint and passes the oldest
// token on. A token with tlast set flushes every held token. When TABLE_DEPTH is not a power of
// two, the remainder is found by folding the fingerprint through small residue tables. With
// deduplication disabled, each token is passed on directly. After reset and after every clear
// transaction the table is swept, one entry per cycle, while no input is taken. Results of up
// to two finished transactions wait in an output queue, so input continues while results are
// pending.
`default_nettype none

module ngram_dedup_token_filter_core #(
  parameter int unsigned TABLE_DEPTH = ndf_pkg::TableDepthDefault,
  parameter int unsigned MAX_NGRAM   = ndf_pkg::MaxNgramDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [ndf_pkg::TokenW-1:0]     s_axis_tdata,  // token
  input  wire logic                           s_axis_tlast,  // window_last
  input  wire logic                           s_axis_tuser,  // func
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [95:0]                    m_axis_tdata,  // token_out, checked, duplicates
  output logic                                m_axis_tlast,  // run_last
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ndf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [ndf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ndf_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_NGRAM + 1);
  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned FD   = 2 * MAX_NGRAM;
  localparam int unsigned FW   = $clog2(FD);
  localparam int unsigned FCW  = $clog2(FD + 1);
  localparam bit          POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  ndf_state_e state_q, state_d;

  logic [NgramW-1:0] ngram_q;
  logic              dedup_q;
  logic [NW-1:0]     n_eff, fill_q;
  logic [CountW-1:0] chk_q, dup_q;
  logic [TokenW-1:0] tok_q;
  logic              last_q;
  logic [NW-1:0]     item_cnt_q;
  logic [AW-1:0]     clr_addr_q, idx_q, mod_idx;
  logic              mod_done;
  logic              accept, hit;

  logic push_win, shift_win, fifo_push, fifo_sel_tok, hash_start, mod_start;
  logic mem_rd, mem_wr, clr_wr, chk_inc, dup_inc, sq_push;

  // Window cells.
  logic [MAX_NGRAM-1:0][TokenW-1:0] win;
  for (genvar g = 0; g < MAX_NGRAM; g++) begin : g_win
    logic [TokenW-1:0] nbr;
    if (g == MAX_NGRAM - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = win[g+1];
    end
    ndf_cell u_cell (
      .clk_i      (clk_i),
      .load_en_i  (push_win && (fill_q == NW'(g))),
      .load_tok_i (s_axis_tdata),
      .shift_en_i (shift_win),
      .nbr_tok_i  (nbr),
      .tok_o      (win[g])
    );
  end

  logic           hash_done;
  logic [FpW-1:0] fp;

  ndf_hash #(.MAX_NGRAM(MAX_NGRAM)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .n_i     (n_eff),
    .win_i   (win),
    .done_o  (hash_done),
    .fp_o    (fp)
  );

  always_comb begin
    if (ngram_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(ngram_q) > int'(MAX_NGRAM)) begin
      n_eff = NW'(MAX_NGRAM);
    end else begin
      n_eff = NW'(ngram_q);
    end
  end

  // Remainder of the fingerprint by the table depth.
  if (POW2) begin : g_mod_mask
    assign mod_idx  = fp[AW-1:0];
    assign mod_done = 1'b1;
  end else begin : g_mod_fold
    localparam int unsigned NNIB = FpW / 4;
    localparam int unsigned RW   = AW + 4;
    logic [AW-1:0] nib_res [NNIB][16];
    logic [RW-1:0] sum, red, sum_q;
    logic [AW-1:0] r_q;
    logic [1:0]    mstep_q;
    for (genvar p = 0; p < NNIB; p++) begin : g_pos
      for (genvar v = 0; v < 16; v++) begin : g_val
        assign nib_res[p][v] = AW'(nib_weight(p, v, TABLE_DEPTH));
      end
    end
    always_comb begin
      sum = '0;
      for (int p = 0; p < NNIB; p++) begin
        sum = sum + RW'(nib_res[p][fp[4*p +: 4]]);
      end
    end
    always_comb begin
      red = sum_q;
      for (int k = 3; k >= 0; k--) begin
        if (red >= RW'(TABLE_DEPTH << k)) begin
          red = red - RW'(TABLE_DEPTH << k);
        end
      end
    end
    assign mod_done = (mstep_q == 2'd2);
    assign mod_idx  = r_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mstep_q <= '0;
      end else if (mod_start) begin
        mstep_q <= '0;
      end else if (state_q == ST_MOD && !mod_done) begin
        mstep_q <= mstep_q + 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (state_q == ST_MOD && mstep_q == 2'd0) begin
        sum_q <= sum;
      end
      if (state_q == ST_MOD && mstep_q == 2'd1) begin
        r_q <= AW'(red);
      end
    end
  end

  // Fingerprint table.
  logic [FpW-1:0] mem [TABLE_DEPTH];
  logic [FpW-1:0] rdata_q;
  logic [AW-1:0]  wa;
  logic [FpW-1:0] wd;

  assign wa = clr_wr ? clr_addr_q : idx_q;
  assign wd = clr_wr ? '0 : fp;

  always_ff @(posedge clk_i) begin
    if (mem_wr || clr_wr) begin
      mem[wa] <= wd;
    end
    if (mem_rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign hit = (rdata_q == fp);

  // Output token queue and per-transaction count queue.
  logic [TokenW-1:0] fifo [FD];
  logic [FW-1:0]     fwp_q, frp_q;
  logic [FCW-1:0]    fcnt_q;
  logic [NW-1:0]     sq_n   [2];
  logic [CountW-1:0] sq_chk [2];
  logic [CountW-1:0] sq_dup [2];
  logic              swp_q, srp_q;
  logic [1:0]        scnt_q;
  logic [NW-1:0]     d_q, d_inc;
  logic              pop;

  assign d_inc         = d_q + 1'b1;
  assign m_axis_tvalid = (scnt_q != 2'd0);
  assign m_axis_tlast  = (d_inc == sq_n[srp_q]);
  assign m_axis_tdata  = {sq_dup[srp_q], sq_chk[srp_q], fifo[frp_q]};
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && (scnt_q != 2'd2)
                         && (fcnt_q <= FCW'(MAX_NGRAM));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == FUNC_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (!dedup_q) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (fill_q >= n_eff) begin
          state_d = ST_HASH;
        end else if (last_q) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_HASH:  if (hash_done) state_d = ST_MOD;
      ST_MOD:   if (mod_done) state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      ST_CMP:   state_d = ST_CHECK;
      ST_FLUSH: if (fill_q == '0) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    push_win     = 1'b0;
    shift_win    = 1'b0;
    fifo_push    = 1'b0;
    fifo_sel_tok = 1'b0;
    hash_start   = 1'b0;
    mod_start    = 1'b0;
    mem_rd       = 1'b0;
    mem_wr       = 1'b0;
    clr_wr       = 1'b0;
    chk_inc      = 1'b0;
    dup_inc      = 1'b0;
    sq_push      = 1'b0;
    case (state_q)
      ST_CLEAR: clr_wr = 1'b1;
      ST_IDLE: begin
        push_win = accept && (s_axis_tuser == FUNC_PUSH) && dedup_q
                   && (fill_q < NW'(MAX_NGRAM));
      end
      ST_CHECK: hash_start = (fill_q >= n_eff);
      ST_HASH:  mod_start = hash_done;
      ST_MOD:   ;
      ST_READ:  mem_rd = 1'b1;
      ST_CMP: begin
        chk_inc   = 1'b1;
        dup_inc   = hit;
        mem_wr    = !hit;
        fifo_push = !hit;
        shift_win = 1'b1;
      end
      ST_FLUSH: begin
        if (fill_q != '0) begin
          fifo_push = 1'b1;
          shift_win = 1'b1;
        end else if (!dedup_q) begin
          fifo_push    = 1'b1;
          fifo_sel_tok = 1'b1;
        end
      end
      ST_FIN:  sq_push = (item_cnt_q != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ngram_q    <= GRAM_LEN_RST;
      dedup_q    <= DEDUP_EN_RST;
      fill_q     <= '0;
      chk_q      <= '0;
      dup_q      <= '0;
      item_cnt_q <= '0;
      clr_addr_q <= '0;
      fwp_q      <= '0;
      frp_q      <= '0;
      fcnt_q     <= '0;
      swp_q      <= 1'b0;
      srp_q      <= 1'b0;
      scnt_q     <= '0;
      d_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_GRAM_LEN) begin
          ngram_q <= cfg_data_i;
        end else if (cfg_index_i == REG_DEDUP_EN) begin
          dedup_q <= cfg_data_i[0];
        end
      end
      if (push_win) begin
        fill_q <= fill_q + 1'b1;
      end else if (shift_win) begin
        fill_q <= fill_q - 1'b1;
      end
      if (accept && s_axis_tuser == FUNC_CLEAR) begin
        chk_q      <= '0;
        dup_q      <= '0;
        clr_addr_q <= '0;
      end else begin
        if (chk_inc && chk_q != '1) chk_q <= chk_q + 1'b1;
        if (dup_inc && dup_q != '1) dup_q <= dup_q + 1'b1;
        if (clr_wr) clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (accept) begin
        item_cnt_q <= '0;
      end else if (fifo_push) begin
        item_cnt_q <= item_cnt_q + 1'b1;
      end
      if (fifo_push) begin
        fwp_q <= (fwp_q == FW'(FD - 1)) ? '0 : fwp_q + 1'b1;
      end
      if (pop) begin
        frp_q <= (frp_q == FW'(FD - 1)) ? '0 : frp_q + 1'b1;
      end
      fcnt_q <= fcnt_q + FCW'(fifo_push) - FCW'(pop);
      if (sq_push) swp_q <= !swp_q;
      if (pop) begin
        if (m_axis_tlast) begin
          srp_q <= !srp_q;
          d_q   <= '0;
        end else begin
          d_q <= d_inc;
        end
      end
      scnt_q <= scnt_q + 2'(sq_push) - 2'(pop && m_axis_tlast);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_MOD && mod_done) begin
      idx_q <= mod_idx;
    end
    if (fifo_push) begin
      fifo[fwp_q] <= fifo_sel_tok ? tok_q : win[0];
    end
    if (sq_push) begin
      sq_n[swp_q]   <= item_cnt_q;
      sq_chk[swp_q] <= chk_q;
      sq_dup[swp_q] <= dup_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= NW'(MAX_NGRAM))
    else $error("window fill above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fcnt_q <= FCW'(FD))
    else $error("output queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> fcnt_q != '0)
    else $error("result offered with empty token queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == ST_CMP |=> state_q == ST_CHECK)
    else $error("compare not followed by check");

endmodule

`default_nettype wire

FILE: rtl/core/ndf_cell.sv
`default_nettype none

module ndf_cell (
  input  wire logic                      clk_i,
  input  wire logic                      load_en_i,
  input  wire logic [ndf_pkg::TokenW-1:0] load_tok_i,
  input  wire logic                      shift_en_i,
  input  wire logic [ndf_pkg::TokenW-1:0] nbr_tok_i,
  output logic      [ndf_pkg::TokenW-1:0] tok_o
);
  import ndf_pkg::*;

  logic [TokenW-1:0] tok_q, tok_d;

  always_comb begin
    tok_d = tok_q;
    if (shift_en_i) begin
      tok_d = nbr_tok_i;
    end else if (load_en_i) begin
      tok_d = load_tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: rtl/core/ndf_hash.sv
`default_nettype none

module ndf_hash #(
  parameter int unsigned MAX_NGRAM = ndf_pkg::MaxNgramDefault,
  localparam int unsigned NW = $clog2(MAX_NGRAM + 1)
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic [NW-1:0]                             n_i,
  input  wire logic [MAX_NGRAM-1:0][ndf_pkg::TokenW-1:0] win_i,
  output logic                                           done_o,
  output logic      [ndf_pkg::FpW-1:0]                   fp_o
);
  import ndf_pkg::*;

  localparam int unsigned IW = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;

  logic [FpW-1:0] coef [MAX_NGRAM];

  for (genvar g = 0; g < MAX_NGRAM; g++) begin : g_coef
    assign coef[g] = b_coef(g);
  end

  logic              issue_q, issue_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [NW-1:0]     left_q, left_d;
  logic              s1_vld_q, s1_last_q, done_q;
  logic [FpW-1:0]    pl_q, pl_d;
  logic [31:0]       ph_q, ph_d;
  logic [FpW-1:0]    h_q, h_d, x;
  logic [TokenW-1:0] t;
  logic [FpW-1:0]    c;

  assign t = win_i[idx_q];
  assign c = coef[idx_q];

  always_comb begin
    issue_d = issue_q;
    idx_d   = idx_q;
    left_d  = left_q;
    if (start_i) begin
      issue_d = 1'b1;
      idx_d   = '0;
      left_d  = n_i;
    end else if (issue_q) begin
      idx_d  = idx_q + 1'b1;
      left_d = left_q - 1'b1;
      if (left_q == NW'(1)) begin
        issue_d = 1'b0;
      end
    end
  end

  always_comb begin
    pl_d = 64'(t) * 64'(c[31:0]);
    ph_d = 32'(t * c[63:32]);
  end

  always_comb begin
    x   = h_q ^ (pl_q + {ph_q, 32'b0});
    h_d = h_q;
    if (start_i) begin
      h_d = '0;
    end else if (s1_vld_q) begin
      h_d = (x << 13) | (x >> 19);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      idx_q     <= '0;
      left_q    <= '0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      issue_q   <= issue_d;
      idx_q     <= idx_d;
      left_q    <= left_d;
      s1_vld_q  <= issue_q && !start_i;
      s1_last_q <= issue_q && (left_q == NW'(1));
      done_q    <= s1_vld_q && s1_last_q && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    ph_q <= ph_d;
    h_q  <= h_d;
  end

  assign done_o = done_q;
  assign fp_o   = h_q;

endmodule

`default_nettype wire
